// File: rtl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Types and constants shared by the LFU cache cells and top level.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int SLOT_W_MAX      = 8;
    localparam int CNT_W_MAX       = 32;
    localparam int CAP_W           = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic               operation;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] read_value;
    } t_rsp;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_USE,
        ACT_REPLACE,
        ACT_INSERT
    } t_act;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } t_state;

    // search record handed from cell to cell
    typedef struct packed {
        logic                  found;
        logic [SLOT_W_MAX-1:0] m_slot;
        logic [31:0]           m_value;
        logic [SLOT_W_MAX-1:0] m_rank;
        logic                  free_ok;
        logic [SLOT_W_MAX-1:0] free_slot;
        logic                  have;
        logic [SLOT_W_MAX-1:0] v_slot;
        logic [CNT_W_MAX-1:0]  v_cnt;
        logic [SLOT_W_MAX-1:0] v_rank;
    } t_carry;

    // update broadcast to all cells
    typedef struct packed {
        t_act                  act;
        logic [SLOT_W_MAX-1:0] slot;
        logic [SLOT_W_MAX-1:0] rank;
        logic                  wr_val;
        logic [31:0]           key;
        logic [31:0]           value;
    } t_upd;

endpackage

// File: rtl/lfu_cell.sv
// ----------------------------------------------------------------------------
// lfu_cell
// One cache entry; folds its entry into the passing search record.
// ----------------------------------------------------------------------------
module lfu_cell #(
    parameter int DEPTH       = 16,
    parameter int COUNT_WIDTH = 16,
    parameter int IDX         = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [31:0]     i_key,
    input  lfu_pkg::t_carry i_carry,
    output lfu_pkg::t_carry o_carry,
    input  lfu_pkg::t_upd   i_upd
);
    import lfu_pkg::*;

    localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = COUNT_WIDTH;
    localparam logic [SLOT_W_MAX-1:0] MY_SLOT = SLOT_W_MAX'(IDX);

    logic          r_valid;
    logic [31:0]   r_key;
    logic [31:0]   r_value;
    logic [CW-1:0] r_cnt;
    logic [SW-1:0] r_rank;
    t_carry        r_carry;
    t_carry        n_carry;

    logic          self;
    logic          older;
    logic [CW-1:0] best_cnt;
    logic [SW-1:0] best_rank;

    always_comb begin
        best_cnt  = i_carry.v_cnt[CW-1:0];
        best_rank = i_carry.v_rank[SW-1:0];
        n_carry   = i_carry;
        if (!i_carry.found && r_valid && r_key == i_key) begin
            n_carry.found   = 1'b1;
            n_carry.m_slot  = MY_SLOT;
            n_carry.m_value = r_value;
            n_carry.m_rank  = SLOT_W_MAX'(r_rank);
        end
        if (!i_carry.free_ok && !r_valid) begin
            n_carry.free_ok   = 1'b1;
            n_carry.free_slot = MY_SLOT;
        end
        if (r_valid && (!i_carry.have || r_cnt < best_cnt ||
                        (r_cnt == best_cnt && r_rank > best_rank))) begin
            n_carry.have   = 1'b1;
            n_carry.v_slot = MY_SLOT;
            n_carry.v_cnt  = CNT_W_MAX'(r_cnt);
            n_carry.v_rank = SLOT_W_MAX'(r_rank);
        end
    end

    always_ff @(posedge i_clk) begin
        r_carry <= n_carry;
    end

    assign o_carry = r_carry;

    assign self  = (i_upd.slot == MY_SLOT);
    assign older = r_valid && (r_rank < i_upd.rank[SW-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            case (i_upd.act)
                ACT_USE: begin
                    if (self) begin
                        if (r_cnt != {CW{1'b1}}) begin
                            r_cnt <= r_cnt + CW'(1);
                        end
                        r_rank <= '0;
                        if (i_upd.wr_val) begin
                            r_value <= i_upd.value;
                        end
                    end else if (older) begin
                        r_rank <= r_rank + SW'(1);
                    end
                end
                ACT_REPLACE: begin
                    if (self) begin
                        r_key   <= i_upd.key;
                        r_value <= i_upd.value;
                        r_cnt   <= CW'(1);
                        r_rank  <= '0;
                    end else if (older) begin
                        r_rank <= r_rank + SW'(1);
                    end
                end
                ACT_INSERT: begin
                    if (self) begin
                        r_valid <= 1'b1;
                        r_key   <= i_upd.key;
                        r_value <= i_upd.value;
                        r_cnt   <= CW'(1);
                        r_rank  <= '0;
                    end else if (r_valid) begin
                        r_rank <= r_rank + SW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: rtl/lfu_cache_lru_tiebreak.sv
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak
// LFU key-value cache with LRU tie-break, built as a row of entry cells.
//
//   channel | valid      | ready       | data
//   in      | i_in_valid | o_in_ready  | i_in_data  (t_req)
//   out     | o_out_valid| i_out_ready | o_out_data (t_rsp)
//   cfg     | i_cfg_valid| o_cfg_ready | i_cfg_data (capacity)
//
// A transaction steps through scan, apply and idle: in scan the search record
// ripples through the registered cell row, then the apply step, then idle.
// Synchronous active-low reset empties the cache and sets capacity to 16.
// A stalled output holds the apply step; the next input waits until it is done.
// ----------------------------------------------------------------------------
module lfu_cache_lru_tiebreak #(
    parameter int DEPTH       = lfu_pkg::DEPTH_DEF,
    parameter int COUNT_WIDTH = lfu_pkg::COUNT_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  lfu_pkg::t_req             i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output lfu_pkg::t_rsp             o_out_data,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [lfu_pkg::CAP_W-1:0] i_cfg_data
);
    import lfu_pkg::*;

    localparam int FW = $clog2(DEPTH + 1);
    localparam int CW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_state        r_state;
    t_state        n_state;
    logic [CW-1:0] r_cnt;
    logic [CAP_W-1:0] r_cap;
    logic [FW-1:0] r_filled;
    t_req          r_req;
    logic          r_out_valid;
    t_rsp          r_out;

    t_carry        chain [DEPTH+1];
    t_carry        fin;
    t_upd          upd;
    t_rsp          rsp;
    logic          fire;
    logic [FW-1:0] cap_eff;

    assign chain[0] = '0;
    assign fin      = chain[DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        lfu_cell #(
            .DEPTH      (DEPTH),
            .COUNT_WIDTH(COUNT_WIDTH),
            .IDX        (g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_key  (r_req.key),
            .i_carry(chain[g]),
            .o_carry(chain[g+1]),
            .i_upd  (upd)
        );
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign cap_eff = (32'(r_cap) > 32'(DEPTH)) ? FW'(DEPTH) : FW'(r_cap);

    always_comb begin
        n_state    = r_state;
        fire       = 1'b0;
        rsp        = '0;
        upd        = '0;
        upd.act    = ACT_NONE;
        upd.key    = r_req.key;
        upd.value  = r_req.value;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_cnt == CW'(DEPTH - 1)) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (!r_out_valid || i_out_ready) begin
                    fire    = 1'b1;
                    n_state = ST_IDLE;
                    if (r_req.operation == OP_GET) begin
                        if (fin.found) begin
                            rsp.hit        = 1'b1;
                            rsp.read_value = fin.m_value;
                            upd.act        = ACT_USE;
                            upd.slot       = fin.m_slot;
                            upd.rank       = fin.m_rank;
                        end
                    end else if (cap_eff != '0) begin
                        if (fin.found) begin
                            rsp.hit    = 1'b1;
                            upd.act    = ACT_USE;
                            upd.wr_val = 1'b1;
                            upd.slot   = fin.m_slot;
                            upd.rank   = fin.m_rank;
                        end else if (r_filled >= cap_eff) begin
                            if (fin.have) begin
                                upd.act  = ACT_REPLACE;
                                upd.slot = fin.v_slot;
                                upd.rank = fin.v_rank;
                            end
                        end else if (fin.free_ok) begin
                            upd.act  = ACT_INSERT;
                            upd.slot = fin.free_slot;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_cap       <= CAP_RESET;
            r_filled    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            if (r_state == ST_SCAN) begin
                r_cnt <= r_cnt + CW'(1);
            end else begin
                r_cnt <= '0;
            end
            if (upd.act == ACT_INSERT) begin
                r_filled <= r_filled + FW'(1);
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_req <= i_in_data;
        end
        if (fire) begin
            r_out <= rsp;
        end
    end

endmodule
